// ===== rtl/core/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Widths, sequencer states and region codes shared by the rasterizer files.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int COORD_BITS = 11;
  localparam int STEP_W     = COORD_BITS + 1;
  localparam int OUT_W      = COORD_BITS + 2;
  localparam int SUM_W      = COORD_BITS + 3;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int TX_W       = STEP_W + 1;
  localparam int MUL_A_W    = SQ_W;
  localparam int MUL_B_W    = 2 * TX_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int DEC_W      = PROD_W + 2;

  typedef enum logic [1:0] {
    REG_IDLE = 2'd0,
    REG_ONE  = 2'd1,
    REG_TWO  = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_START = 2'd1,
    RES_FOUR  = 2'd2
  } res_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S0,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_R1A,
    ST_R1B,
    ST_R1C,
    ST_R1D,
    ST_R1E,
    ST_R1F,
    ST_R1G,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_T5,
    ST_R2B,
    ST_R2C,
    ST_R2D,
    ST_R2E,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Traces one quadrant of an axis-aligned ellipse and mirrors it to four points.
// ----------------------------------------------------------------------------
// A start beat (func 0) carries two control points; the centre is the anchor
// x and the corner y, and the radii are the absolute differences. It returns
// the two points on the vertical axis. Each advance beat (func 1) makes one
// midpoint step and returns the four mirrored points; last marks y reaching 0.
// An advance beat while no ellipse is running returns a beat with all zeros.
// The block takes one input beat at a time: in_ready is high only while the
// sequencer is idle. One shared multiplier with a registered product and a
// small sequencer do all the arithmetic, so the length of each beat is set
// by the number of multiplies in the step. The sequencer goes back to idle
// as it loads each result into the output register, and only then does it
// take the next beat.
// The result sits in an output register; while the receiver stalls the block
// still accepts and computes the next beat and waits only to load its result.
// Reset clears the sequencer, the region and the output valid.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [mer_pkg::COORD_BITS-1:0]    in_anchor_x,
  input  logic [mer_pkg::COORD_BITS-1:0]    in_anchor_y,
  input  logic [mer_pkg::COORD_BITS-1:0]    in_corner_x,
  input  logic [mer_pkg::COORD_BITS-1:0]    in_corner_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_valid_res,
  output logic                              out_all_four,
  output logic signed [mer_pkg::OUT_W-1:0]  out_point_a_x,
  output logic signed [mer_pkg::OUT_W-1:0]  out_point_a_y,
  output logic signed [mer_pkg::OUT_W-1:0]  out_point_b_x,
  output logic signed [mer_pkg::OUT_W-1:0]  out_point_b_y,
  output logic signed [mer_pkg::OUT_W-1:0]  out_point_c_x,
  output logic signed [mer_pkg::OUT_W-1:0]  out_point_c_y,
  output logic signed [mer_pkg::OUT_W-1:0]  out_point_d_x,
  output logic signed [mer_pkg::OUT_W-1:0]  out_point_d_y,
  output logic                              out_last
);
  import mer_pkg::*;

  state_t    state_r, state_nxt;
  region_t   region_r, region_nxt;
  res_kind_t kind_r, kind_nxt;

  logic [COORD_BITS-1:0]   cx_r, cx_nxt;
  logic [COORD_BITS-1:0]   cy_r, cy_nxt;
  logic [COORD_BITS-1:0]   rx_r, rx_nxt;
  logic [STEP_W-1:0]       x_r, x_nxt;
  logic [COORD_BITS-1:0]   y_r, y_nxt;
  logic [SQ_W-1:0]         rx2_r, rx2_nxt;
  logic [SQ_W-1:0]         ry2_r, ry2_nxt;
  logic [PROD_W-1:0]       t_r, t_nxt;
  logic signed [DEC_W-1:0] d_r, d_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    res_valid_r, res_valid_nxt;
  logic                    all_four_r, all_four_nxt;
  logic                    last_r, last_nxt;
  logic [OUT_W-1:0]        pax_r, pax_nxt, pay_r, pay_nxt;
  logic [OUT_W-1:0]        pbx_r, pbx_nxt, pby_r, pby_nxt;
  logic [OUT_W-1:0]        pcx_r, pcx_nxt, pcy_r, pcy_nxt;
  logic [OUT_W-1:0]        pdx_r, pdx_nxt, pdy_r, pdy_nxt;

  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       p;

  logic                    in_fire;
  logic                    can_load;
  logic                    d_neg;
  logic                    d_pos;
  logic                    y_zero;
  logic [COORD_BITS-1:0]   y_dec;
  logic [TX_W-1:0]         tx;
  logic signed [DEC_W-1:0] p4, p8, rx2_4, ry2_4, rx2_s;
  logic [SUM_W-1:0]        cx_e, cy_e, x_e, y_e;
  logic [SUM_W-1:0]        sum_xp, sum_xm, sum_yp, sum_ym;

  mer_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign can_load  = !out_valid_r || out_ready;
  assign d_neg     = d_r[DEC_W-1];
  assign d_pos     = !d_r[DEC_W-1] && (d_r != '0);
  assign y_zero    = (y_r == '0);
  assign y_dec     = y_r - COORD_BITS'(1);
  assign tx        = {x_r, 1'b1};
  assign p4        = DEC_W'({p, 2'b00});
  assign p8        = DEC_W'({p, 3'b000});
  assign rx2_4     = DEC_W'({rx2_r, 2'b00});
  assign ry2_4     = DEC_W'({ry2_r, 2'b00});
  assign rx2_s     = DEC_W'(rx2_r);
  assign cx_e      = SUM_W'(cx_r);
  assign cy_e      = SUM_W'(cy_r);
  assign x_e       = SUM_W'(x_r);
  assign y_e       = SUM_W'(y_r);
  assign sum_xp    = cx_e + x_e;
  assign sum_xm    = cx_e - x_e;
  assign sum_yp    = cy_e + y_e;
  assign sum_ym    = cy_e - y_e;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_func) begin
            state_nxt = ST_S0;
          end else begin
            case (region_r)
              REG_ONE: state_nxt = ST_R1A;
              REG_TWO: state_nxt = ST_R2B;
              default: state_nxt = ST_OUT;
            endcase
          end
        end
      end
      ST_S0:  state_nxt = ST_S1;
      ST_S1:  state_nxt = ST_S2;
      ST_S2:  state_nxt = ST_S3;
      ST_S3:  state_nxt = ST_OUT;
      ST_R1A: state_nxt = ST_R1B;
      ST_R1B: state_nxt = ST_R1C;
      ST_R1C: state_nxt = (t_r < p) ? ST_R1D : ST_T0;
      ST_R1D: state_nxt = ST_R1E;
      ST_R1E: state_nxt = d_neg ? ST_OUT : ST_R1F;
      ST_R1F: state_nxt = ST_R1G;
      ST_R1G: state_nxt = ST_OUT;
      ST_T0:  state_nxt = ST_T1;
      ST_T1:  state_nxt = ST_T2;
      ST_T2:  state_nxt = ST_T3;
      ST_T3:  state_nxt = ST_T4;
      ST_T4:  state_nxt = ST_T5;
      ST_T5:  state_nxt = ST_R2B;
      ST_R2B: state_nxt = ST_R2C;
      ST_R2C: state_nxt = d_pos ? ST_OUT : ST_R2D;
      ST_R2D: state_nxt = ST_R2E;
      ST_R2E: state_nxt = ST_OUT;
      ST_OUT: state_nxt = can_load ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_S0: begin
        mul_a = MUL_A_W'(rx_r);
        mul_b = MUL_B_W'(rx_r);
      end
      ST_S1: begin
        mul_a = MUL_A_W'(y_r);
        mul_b = MUL_B_W'(y_r);
      end
      ST_S2, ST_R1B, ST_R1F: begin
        mul_a = rx2_r;
        mul_b = MUL_B_W'(y_r);
      end
      ST_R1A, ST_R1D, ST_R2D: begin
        mul_a = ry2_r;
        mul_b = MUL_B_W'(x_r);
      end
      ST_T0: begin
        mul_a = MUL_A_W'(tx);
        mul_b = MUL_B_W'(tx);
      end
      ST_T1: begin
        mul_a = ry2_r;
        mul_b = p[MUL_B_W-1:0];
      end
      ST_T2: begin
        mul_a = MUL_A_W'(y_dec);
        mul_b = MUL_B_W'(y_dec);
      end
      ST_T3: begin
        mul_a = rx2_r;
        mul_b = p[MUL_B_W-1:0];
      end
      ST_T4: begin
        mul_a = rx2_r;
        mul_b = MUL_B_W'(ry2_r);
      end
      ST_R2B: begin
        mul_a = rx2_r;
        mul_b = MUL_B_W'(y_dec);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    region_nxt    = region_r;
    kind_nxt      = kind_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rx_nxt        = rx_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rx2_nxt       = rx2_r;
    ry2_nxt       = ry2_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_valid_nxt = res_valid_r;
    all_four_nxt  = all_four_r;
    last_nxt      = last_r;
    pax_nxt       = pax_r;
    pay_nxt       = pay_r;
    pbx_nxt       = pbx_r;
    pby_nxt       = pby_r;
    pcx_nxt       = pcx_r;
    pcy_nxt       = pcy_r;
    pdx_nxt       = pdx_r;
    pdy_nxt       = pdy_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_func) begin
            kind_nxt = RES_START;
            cx_nxt   = in_anchor_x;
            cy_nxt   = in_corner_y;
            rx_nxt   = (in_corner_x > in_anchor_x) ? in_corner_x - in_anchor_x
                                                   : in_anchor_x - in_corner_x;
            y_nxt    = (in_corner_y > in_anchor_y) ? in_corner_y - in_anchor_y
                                                   : in_anchor_y - in_corner_y;
            x_nxt    = '0;
          end else if (region_r == REG_ONE || region_r == REG_TWO) begin
            kind_nxt = RES_FOUR;
          end else begin
            kind_nxt = RES_NONE;
          end
        end
      end
      ST_S1: rx2_nxt = p[SQ_W-1:0];
      ST_S2: ry2_nxt = p[SQ_W-1:0];
      ST_S3: d_nxt   = ry2_4 - p4 + rx2_s;
      ST_R1B: t_nxt  = p;
      ST_R1C: begin
        if (t_r < p) begin
          x_nxt = x_r + STEP_W'(1);
        end
      end
      ST_R1E: begin
        d_nxt = d_r + p8 + ry2_4;
        if (!d_neg) begin
          y_nxt = y_dec;
        end
      end
      ST_R1G: d_nxt = d_r - p8;
      ST_T0:  region_nxt = REG_TWO;
      ST_T2:  d_nxt = DEC_W'(p);
      ST_T4:  d_nxt = d_r + p4;
      ST_T5:  d_nxt = d_r - p4;
      ST_R2B: y_nxt = y_dec;
      ST_R2C: begin
        d_nxt = d_r + rx2_4 - p8;
        if (!d_pos) begin
          x_nxt = x_r + STEP_W'(1);
        end
      end
      ST_R2E: d_nxt = d_r + p8;
      ST_OUT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          case (kind_r)
            RES_START: begin
              res_valid_nxt = 1'b1;
              all_four_nxt  = 1'b0;
              last_nxt      = y_zero;
              region_nxt    = y_zero ? REG_IDLE : REG_ONE;
              pax_nxt       = sum_xp[OUT_W-1:0];
              pay_nxt       = sum_yp[OUT_W-1:0];
              pbx_nxt       = sum_xp[OUT_W-1:0];
              pby_nxt       = sum_ym[OUT_W-1:0];
              pcx_nxt       = '0;
              pcy_nxt       = '0;
              pdx_nxt       = '0;
              pdy_nxt       = '0;
            end
            RES_FOUR: begin
              res_valid_nxt = 1'b1;
              all_four_nxt  = 1'b1;
              last_nxt      = y_zero;
              if (y_zero) begin
                region_nxt = REG_IDLE;
              end
              pax_nxt       = sum_xp[OUT_W-1:0];
              pay_nxt       = sum_yp[OUT_W-1:0];
              pbx_nxt       = sum_xp[OUT_W-1:0];
              pby_nxt       = sum_ym[OUT_W-1:0];
              pcx_nxt       = sum_xm[OUT_W-1:0];
              pcy_nxt       = sum_yp[OUT_W-1:0];
              pdx_nxt       = sum_xm[OUT_W-1:0];
              pdy_nxt       = sum_ym[OUT_W-1:0];
            end
            default: begin
              res_valid_nxt = 1'b0;
              all_four_nxt  = 1'b0;
              last_nxt      = 1'b0;
              pax_nxt       = '0;
              pay_nxt       = '0;
              pbx_nxt       = '0;
              pby_nxt       = '0;
              pcx_nxt       = '0;
              pcy_nxt       = '0;
              pdx_nxt       = '0;
              pdy_nxt       = '0;
            end
          endcase
        end
      end
      default: begin
        d_nxt = d_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      region_r    <= REG_IDLE;
      kind_r      <= RES_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      region_r    <= region_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    rx_r        <= rx_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    rx2_r       <= rx2_nxt;
    ry2_r       <= ry2_nxt;
    t_r         <= t_nxt;
    d_r         <= d_nxt;
    res_valid_r <= res_valid_nxt;
    all_four_r  <= all_four_nxt;
    last_r      <= last_nxt;
    pax_r       <= pax_nxt;
    pay_r       <= pay_nxt;
    pbx_r       <= pbx_nxt;
    pby_r       <= pby_nxt;
    pcx_r       <= pcx_nxt;
    pcy_r       <= pcy_nxt;
    pdx_r       <= pdx_nxt;
    pdy_r       <= pdy_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_valid_r;
  assign out_all_four  = all_four_r;
  assign out_last      = last_r;
  assign out_point_a_x = pax_r;
  assign out_point_a_y = pay_r;
  assign out_point_b_x = pbx_r;
  assign out_point_b_y = pby_r;
  assign out_point_c_x = pcx_r;
  assign out_point_c_y = pcy_r;
  assign out_point_d_x = pdx_r;
  assign out_point_d_y = pdy_r;

endmodule

// ===== rtl/core/mer_mul.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer shared multiplier
// Unsigned multiplier with a registered product, reused by every step.
// ----------------------------------------------------------------------------
module mer_mul (
  input  logic                       clk,
  input  logic [mer_pkg::MUL_A_W-1:0] a,
  input  logic [mer_pkg::MUL_B_W-1:0] b,
  output logic [mer_pkg::PROD_W-1:0]  p
);
  import mer_pkg::*;

  logic [PROD_W-1:0] p_r;
  logic [PROD_W-1:0] p_nxt;

  assign p_nxt = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule
